### rtl/i2cmb_pkg.sv
// shared types and constants of the i2c master byte engine
`default_nettype none
package i2cmb_pkg;

	// operation codes as they arrive on the input channel
	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_START     = 3'd1,
		CMD_STOP      = 3'd2,
		CMD_WRITE     = 3'd3,
		CMD_READ_ACK  = 3'd4,
		CMD_READ_NACK = 3'd5
	} cmd_t;

	// bus phases of the engine
	typedef enum logic [3:0] {
		PH_IDLE       = 4'd0,
		PH_START_HIGH = 4'd1,
		PH_START_LOW  = 4'd2,
		PH_STOP_LOW   = 4'd3,
		PH_STOP_HIGH  = 4'd4,
		PH_BIT_LOW    = 4'd5,
		PH_BIT_HIGH   = 4'd6,
		PH_ACK_LOW    = 4'd7,
		PH_ACK_HIGH   = 4'd8
	} phase_t;

	localparam logic [7:0]  MSB_MASK      = 8'h80;
	localparam logic [3:0]  BITS_PER_BYTE = 4'd8;
	localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;

	// one classified tick as it travels from front to back
	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] wbyte;
		logic       sda;
	} item_t;

	function automatic cmd_t to_cmd(input logic [2:0] code);
		cmd_t c;
		case (code)
			CMD_START:     c = CMD_START;
			CMD_STOP:      c = CMD_STOP;
			CMD_WRITE:     c = CMD_WRITE;
			CMD_READ_ACK:  c = CMD_READ_ACK;
			CMD_READ_NACK: c = CMD_READ_NACK;
			default:       c = CMD_NONE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### rtl/i2c_master_byte_engine_unit.sv
// top level of the i2c master byte engine: front end, queue and bus engine
//
// usage:
//   input channel (in_valid / in_stall) carries one bus tick per transfer:
//   operation, write_byte and the sampled sda_in level. every accepted tick
//   produces exactly one result transfer on the output channel
//   (out_valid / out_stall) with scl_level, sda_release, busy_res, done_res,
//   ack_seen and read_byte as they stand after that tick.
//   phase_ticks is written through cfg_wr_en / cfg_wr_data while idle; the
//   user must keep to that, the block itself does not enforce it.
// order: each tick passes the front register, then the queue, then the
//   result register of the engine.
// throughput: one tick per clock while out_stall is low; each tick is one
//   step of the phase sequencer; the 16-bit tick compare ends each phase.
// reset: arst_n low releases the bus (scl and sda high), clears the engine
//   and empties the queue; phase_ticks returns to 5.
// stall: when out_stall holds, the result register keeps its value, the
//   queue fills up and in_stall rises once the front register cannot move.
`default_nettype none
module i2c_master_byte_engine_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	// tick input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [7:0]  write_byte,
	input  wire logic        sda_in,
	// result output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             scl_level,
	output logic             sda_release,
	output logic             busy_res,
	output logic             done_res,
	output logic             ack_seen,
	output logic [7:0]       read_byte
);
	import i2cmb_pkg::*;

	// phase length register
	logic [15:0] phase_ticks_q;

	// front to queue
	item_t  front_item;
	logic   front_valid;
	logic   queue_full;

	// queue to engine
	item_t  head_item;
	logic   head_valid;
	logic   engine_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RESET;
		end else if (cfg_wr_en) begin
			phase_ticks_q <= cfg_wr_data;
		end
	end

	// classify incoming ticks
	i2cmb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.write_byte (write_byte),
		.sda_in     (sda_in),
		.item       (front_item),
		.item_valid (front_valid),
		.item_stall (queue_full)
	);

	// decouples the front end from the result side
	i2cmb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_stall (queue_full),
		.push_item  (front_item),
		.pop_valid  (head_valid),
		.pop_stall  (engine_stall),
		.pop_item   (head_item)
	);

	// bus phase sequencer, one step per transfer
	i2cmb_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.phase_ticks (phase_ticks_q),
		.pop_valid   (head_valid),
		.pop_stall   (engine_stall),
		.item        (head_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.scl_level   (scl_level),
		.sda_release (sda_release),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.ack_seen    (ack_seen),
		.read_byte   (read_byte)
	);

endmodule
`default_nettype wire

### rtl/i2cmb_front.sv
// front end: takes ticks from the input channel and classifies the operation code
`default_nettype none
module i2cmb_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [2:0]       operation,
	input  wire logic [7:0]       write_byte,
	input  wire logic             sda_in,
	output i2cmb_pkg::item_t      item,
	output logic                  item_valid,
	input  wire logic             item_stall
);
	import i2cmb_pkg::*;

	item_t item_s1;
	logic  valid_s1;

	assign in_stall   = valid_s1 & item_stall;
	assign item       = item_s1;
	assign item_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.cmd   <= to_cmd(operation);
			item_s1.wbyte <= write_byte;
			item_s1.sda   <= sda_in;
		end
	end

endmodule
`default_nettype wire

### rtl/i2cmb_queue.sv
// two-entry queue between the front end and the bus engine
`default_nettype none
module i2cmb_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_stall,
	input  i2cmb_pkg::item_t      push_item,
	output logic                  pop_valid,
	input  wire logic             pop_stall,
	output i2cmb_pkg::item_t      pop_item
);
	import i2cmb_pkg::*;

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_stall = (count_q == 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid & ~push_stall;
	assign pop        = pop_valid & ~pop_stall;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

### rtl/i2cmb_engine.sv
// back end: bus phase sequencer whose state registers form the result register
`default_nettype none
module i2cmb_engine (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [15:0]      phase_ticks,
	input  wire logic             pop_valid,
	output logic                  pop_stall,
	input  i2cmb_pkg::item_t      item,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  scl_level,
	output logic                  sda_release,
	output logic                  busy_res,
	output logic                  done_res,
	output logic                  ack_seen,
	output logic [7:0]            read_byte
);
	import i2cmb_pkg::*;

	phase_t      phase_q, phase_d;
	cmd_t        op_q, op_d;
	logic [3:0]  bit_cnt_q, bit_cnt_d;
	logic [7:0]  shift_q, shift_d;
	logic [15:0] tick_q, tick_d;
	logic        scl_q, scl_d;
	logic        sda_q, sda_d;
	logic        ack_q, ack_d;
	logic        done_q, done_d;
	logic        out_valid_q;
	logic        step;
	logic [15:0] limit;
	logic [15:0] tick_inc;
	logic [3:0]  bit_inc;

	assign pop_stall = out_valid_q & out_stall;
	assign step      = pop_valid & ~pop_stall;
	assign limit     = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
	assign tick_inc  = tick_q + 16'd1;
	assign bit_inc   = bit_cnt_q + 4'd1;

	always_comb begin
		phase_d   = phase_q;
		op_d      = op_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		tick_d    = tick_q;
		scl_d     = scl_q;
		sda_d     = sda_q;
		ack_d     = ack_q;
		done_d    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.cmd != CMD_NONE) begin
				op_d      = item.cmd;
				bit_cnt_d = 4'd0;
				tick_d    = 16'd0;
				case (item.cmd)
					CMD_START: begin
						phase_d = PH_START_HIGH;
						sda_d   = 1'b1;
						scl_d   = 1'b1;
					end
					CMD_STOP: begin
						phase_d = PH_STOP_LOW;
						scl_d   = 1'b0;
						sda_d   = 1'b0;
					end
					default: begin
						shift_d = (item.cmd == CMD_WRITE) ? item.wbyte : 8'd0;
						phase_d = PH_BIT_LOW;
						scl_d   = 1'b0;
						sda_d   = (item.cmd == CMD_WRITE) ?
							((item.wbyte & MSB_MASK) != 8'd0) : 1'b1;
					end
				endcase
			end
		end else if (tick_inc >= limit) begin
			tick_d = 16'd0;
			case (phase_q)
				PH_START_HIGH: begin
					phase_d = PH_START_LOW;
					sda_d   = 1'b0;
				end
				PH_START_LOW: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_STOP_LOW: begin
					phase_d = PH_STOP_HIGH;
					scl_d   = 1'b1;
				end
				PH_STOP_HIGH: begin
					sda_d   = 1'b1;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				PH_BIT_LOW: begin
					phase_d = PH_BIT_HIGH;
					scl_d   = 1'b1;
				end
				PH_BIT_HIGH: begin
					if (op_q == CMD_WRITE) begin
						shift_d = {shift_q[6:0], 1'b0};
					end else begin
						shift_d = {shift_q[6:0], item.sda};
					end
					bit_cnt_d = bit_inc;
					scl_d     = 1'b0;
					if (bit_inc >= BITS_PER_BYTE) begin
						phase_d = PH_ACK_LOW;
						sda_d   = (op_q != CMD_READ_ACK);
					end else begin
						phase_d = PH_BIT_LOW;
						sda_d   = (op_q == CMD_WRITE) ?
							((shift_d & MSB_MASK) != 8'd0) : 1'b1;
					end
				end
				PH_ACK_LOW: begin
					phase_d = PH_ACK_HIGH;
					scl_d   = 1'b1;
				end
				PH_ACK_HIGH: begin
					if (op_q == CMD_WRITE) ack_d = ~item.sda;
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end else begin
			tick_d = tick_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			op_q        <= CMD_NONE;
			bit_cnt_q   <= 4'd0;
			shift_q     <= 8'd0;
			tick_q      <= 16'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ack_q       <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q   <= phase_d;
				op_q      <= op_d;
				bit_cnt_q <= bit_cnt_d;
				shift_q   <= shift_d;
				tick_q    <= tick_d;
				scl_q     <= scl_d;
				sda_q     <= sda_d;
				ack_q     <= ack_d;
				done_q    <= done_d;
			end
			if (!pop_stall) out_valid_q <= pop_valid;
		end
	end

	assign out_valid   = out_valid_q;
	assign scl_level   = scl_q;
	assign sda_release = sda_q;
	assign busy_res    = (phase_q != PH_IDLE);
	assign done_res    = done_q;
	assign ack_seen    = ack_q;
	assign read_byte   = shift_q;

endmodule
`default_nettype wire
